// ===== design/pbs_pkg.sv =====
// Shared types, codes and constants for the packed bit-field store.
`default_nettype none
package pbs_pkg;

   localparam int STORE_BITS_DEF = 2048;

   localparam logic [1:0] FUNC_READ8   = 2'd0;
   localparam logic [1:0] FUNC_WRITE8  = 2'd1;
   localparam logic [1:0] FUNC_READ32  = 2'd2;
   localparam logic [1:0] FUNC_WRITE32 = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] start_bit;
      logic [10:0] end_bit;
      logic [31:0] write_value;
   } pbs_req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        error;
   } pbs_rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic issue;
      logic finish;
   } pbs_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic err;
      logic last_issue;
   } pbs_status_type;

endpackage
`default_nettype wire

// ===== design/pbs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module pbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/pbs_ctrl.sv =====
// Sequencer for the packed bit-field store: clear sweep, byte walk, result hand-off.
`default_nettype none
module pbs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output pbs_pkg::pbs_cmd_type        cmd,
   input  wire pbs_pkg::pbs_status_type status
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.err) begin
               state_in = ST_FIN;
            end else begin
               cmd.issue = 1'b1;
               if (status.last_issue) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // last read byte lands and is merged this cycle
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/pbs_dp.sv =====
// Datapath: request decode, byte window gather, field merge and result register.
`default_nettype none
module pbs_dp #(
   parameter int STORE_BITS = pbs_pkg::STORE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pbs_pkg::pbs_req_type   req_data,
   output pbs_pkg::pbs_rsp_type        rsp_data,
   input  wire pbs_pkg::pbs_cmd_type   cmd,
   output pbs_pkg::pbs_status_type     status
);

   localparam int DEPTH = STORE_BITS / 8;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = (AW > 8) ? AW : 8;

   // decode of the incoming item
   logic [10:0] span_c;
   logic        err8_c, err32_c, is32_c, err_c, wr_c;
   logic [5:0]  width_c;
   logic [2:0]  shift_c;
   logic [5:0]  reach_c;
   logic [2:0]  n_c;
   logic [31:0] wm_c;
   logic [39:0] mask_c, data_c;

   // per-item registers
   logic          err_ff, wr_ff;
   logic [2:0]    shift_ff, n_ff;
   logic [31:0]   wm_ff;
   logic [39:0]   mask_ff, data_ff, window_ff;
   logic [IW-1:0] first_ff;
   logic [2:0]    k_ff, kd_ff;
   logic          pend_ff;
   logic [AW-1:0] clr_addr_ff;
   pbs_pkg::pbs_rsp_type rsp_ff;

   // memory side
   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0]    ram_wd, ram_rd;
   logic [7:0]    mask_b, data_b, merged_b;
   logic [39:0]   shifted;

   function automatic pbs_pkg::pbs_rsp_type rsp_data_next();
      pbs_pkg::pbs_rsp_type r;
      r.error      = err_ff;
      r.read_value = (err_ff || wr_ff) ? 32'd0 : (shifted[31:0] & wm_ff);
      return r;
   endfunction

   always_comb begin
      span_c  = req_data.end_bit - req_data.start_bit;
      is32_c  = (req_data.func == pbs_pkg::FUNC_READ32) ||
                (req_data.func == pbs_pkg::FUNC_WRITE32);
      wr_c    = (req_data.func == pbs_pkg::FUNC_WRITE8) ||
                (req_data.func == pbs_pkg::FUNC_WRITE32);
      err8_c  = (req_data.end_bit < req_data.start_bit) || (span_c > 11'd7) ||
                (32'(req_data.end_bit) >= 32'(STORE_BITS));
      err32_c = (32'(req_data.start_bit) + 32'd31) >= 32'(STORE_BITS);
      err_c   = is32_c ? err32_c : err8_c;
      width_c = is32_c ? 6'd32 : (6'(span_c[2:0]) + 6'd1);
      shift_c = req_data.start_bit[2:0];
      reach_c = 6'(shift_c) + width_c - 6'd1;
      n_c     = 3'(reach_c >> 3) + 3'd1;
      wm_c    = (width_c == 6'd32) ? 32'hffff_ffff : ((32'd1 << width_c) - 32'd1);
      mask_c  = {8'd0, wm_c} << shift_c;
      data_c  = ({8'd0, req_data.write_value} << shift_c) & mask_c;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff   <= err_c;
         wr_ff    <= wr_c;
         shift_ff <= shift_c;
         n_ff     <= n_c;
         wm_ff    <= wm_c;
         mask_ff  <= mask_c;
         data_ff  <= data_c;
         first_ff <= IW'(req_data.start_bit >> 3);
      end
      if (cmd.load) begin
         window_ff <= '0;
      end else if (pend_ff) begin
         window_ff[{kd_ff, 3'b000} +: 8] <= ram_rd;
      end
      if (cmd.issue) begin
         kd_ff <= k_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_data_next();
      end
   end

   assign shifted = window_ff >> shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         pend_ff     <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         pend_ff <= cmd.issue;
         if (cmd.load) begin
            k_ff <= '0;
         end else if (cmd.issue) begin
            k_ff <= k_ff + 3'd1;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   // merge the returning byte with the field bits; writes put it straight back
   always_comb begin
      mask_b   = mask_ff[{kd_ff, 3'b000} +: 8];
      data_b   = data_ff[{kd_ff, 3'b000} +: 8];
      merged_b = (ram_rd & ~mask_b) | data_b;
      if (cmd.clear) begin
         ram_we = 1'b1;
         ram_wa = clr_addr_ff;
         ram_wd = 8'd0;
      end else begin
         ram_we = pend_ff && wr_ff;
         ram_wa = AW'(first_ff + IW'(kd_ff));
         ram_wd = merged_b;
      end
      ram_ra = AW'(first_ff + IW'(k_ff));
   end

   pbs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (cmd.issue),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign status.clr_last   = (clr_addr_ff == AW'(DEPTH - 1));
   assign status.err        = err_ff;
   assign status.last_issue = (k_ff == (n_ff - 3'd1));
   assign rsp_data          = rsp_ff;

endmodule
`default_nettype wire

// ===== design/packed_bitfield_store.sv =====
// Top level of the packed bit-field store: sequencer, datapath and byte RAM.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  request | req_valid req_ready req_data   | in
//  result  | rsp_valid rsp_ready rsp_data   | out
//
// An item reads the n bytes it touches (1 or 2 for 8-bit fields, 4 or 5 for
// 32-bit); a refused item reads none and goes straight to its result.
// The single RAM read port walks the bytes one per cycle; writes merge each byte
// in the cycle after its read, on the write port.
// After reset the store is swept to zero byte by byte, with req_ready low.
// A result waiting on rsp_ready does not stop the next item being accepted.
`default_nettype none
module packed_bitfield_store #(
   parameter int STORE_BITS = pbs_pkg::STORE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pbs_pkg::pbs_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pbs_pkg::pbs_rsp_type      rsp_data
);

   pbs_pkg::pbs_cmd_type    cmd;
   pbs_pkg::pbs_status_type status;

   pbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pbs_dp #(
      .STORE_BITS (STORE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
`default_nettype wire

// ===== tb/packed_bitfield_store_checker.sv =====
// Checker for the packed bit-field store: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module packed_bitfield_store_checker #(
   parameter int STORE_BITS = pbs_pkg::STORE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire pbs_pkg::pbs_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire pbs_pkg::pbs_rsp_type rsp_data,
   output int                        fail_count,
   output int                        pending
);

   localparam int STORE_BYTES = STORE_BITS / 8;

   logic [7:0]           store_bytes [STORE_BYTES];
   pbs_pkg::pbs_rsp_type expected_rsp [$];
   pbs_pkg::pbs_rsp_type want;
   int                   mismatches = 0;

   // Applies one field operation to the byte image and returns the result it gives.
   function automatic pbs_pkg::pbs_rsp_type apply_field_op(pbs_pkg::pbs_req_type r);
      pbs_pkg::pbs_rsp_type res;
      int          lo;
      int          hi;
      int          width;
      int          first;
      int          nbytes;
      int          k;
      logic [63:0] win;
      logic [63:0] mask;
      logic [63:0] data;
      res = '0;
      lo  = r.start_bit;
      if (r.func == pbs_pkg::FUNC_READ8 || r.func == pbs_pkg::FUNC_WRITE8) begin
         hi        = r.end_bit;
         width     = hi - lo + 1;
         res.error = (hi < lo) || (width > 8) || (hi >= STORE_BITS);
      end else begin
         width     = 32;
         hi        = lo + 31;
         res.error = (hi >= STORE_BITS);
      end
      if (res.error)
         return res;
      first  = lo / 8;
      nbytes = hi / 8 - first + 1;
      win    = '0;
      for (k = 0; k < nbytes; k++)
         win[8*k +: 8] = store_bytes[first + k];
      mask = ((64'd1 << width) - 64'd1) << (lo % 8);
      if (r.func == pbs_pkg::FUNC_READ8 || r.func == pbs_pkg::FUNC_READ32) begin
         res.read_value = 32'((win & mask) >> (lo % 8));
      end else begin
         // excess value bits fall outside the mask and are dropped
         data = (64'(r.write_value) << (lo % 8)) & mask;
         win  = (win & ~mask) | data;
         for (k = 0; k < nbytes; k++)
            store_bytes[first + k] = win[8*k +: 8];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (store_bytes[i])
            store_bytes[i] = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, got read_value=%h error=%b",
                        $time, rsp_data.read_value, rsp_data.error);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.read_value !== want.read_value) begin
                  mismatches++;
                  $display("%0t: read_value mismatch: expected %h, got %h",
                           $time, want.read_value, rsp_data.read_value);
               end
               if (rsp_data.error !== want.error) begin
                  mismatches++;
                  $display("%0t: error mismatch: expected %b, got %b",
                           $time, want.error, rsp_data.error);
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_field_op(req_data));
      end
      fail_count <= mismatches;
      pending    <= expected_rsp.size();
   end

endmodule

// ===== tb/packed_bitfield_store_tb.sv =====
// Testbench top for the packed bit-field store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module packed_bitfield_store_tb;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_ITEMS    = 1850;
   localparam int LAST_BIT        = pbs_pkg::STORE_BITS_DEF - 1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   pbs_pkg::pbs_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   pbs_pkg::pbs_rsp_type rsp_data;
   int                   fail_count;
   int                   pending;
   int                   stall_cycles = 0;
   bit                   send_quiet = 1'b0;
   bit                   rsp_quiet = 1'b0;
   bit                   hold_off_pending = 1'b0;

   packed_bitfield_store i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   packed_bitfield_store_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[packed_bitfield_store] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver: random back-pressure, a quiet stretch, and one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_pending = 1'b0;
         end else begin
            rsp_ready <= rsp_quiet || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   function automatic pbs_pkg::pbs_req_type field_req(logic [1:0] func, int start_bit,
                                                      int end_bit, logic [31:0] value);
      pbs_pkg::pbs_req_type r;
      r.func        = func;
      r.start_bit   = 11'(start_bit);
      r.end_bit     = 11'(end_bit);
      r.write_value = value;
      return r;
   endfunction

   // Mostly well-formed spans, half of all items packed into the low bytes so that
   // reads land on earlier writes; the rest is noise, mostly refused for 8-bit functions.
   function automatic pbs_pkg::pbs_req_type random_req();
      pbs_pkg::pbs_req_type r;
      int          pick;
      int          top_bit;
      int          w;
      r.func        = 2'($urandom_range(0, 3));
      r.write_value = $urandom();
      pick          = $urandom_range(0, 99);
      top_bit       = (pick < 50) ? 95 : LAST_BIT;
      if (pick >= 88) begin
         r.start_bit = 11'($urandom());
         r.end_bit   = 11'($urandom());
      end else if (r.func == pbs_pkg::FUNC_READ32 || r.func == pbs_pkg::FUNC_WRITE32) begin
         r.start_bit = 11'($urandom_range(0, top_bit - 31));
         r.end_bit   = 11'($urandom());
      end else begin
         w           = $urandom_range(1, 8);
         r.start_bit = 11'($urandom_range(0, top_bit - w + 1));
         r.end_bit   = 11'(int'(r.start_bit) + w - 1);
      end
      return r;
   endfunction

   task automatic drive_item(input pbs_pkg::pbs_req_type r);
      while (!send_quiet && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      drive_item(field_req(pbs_pkg::FUNC_READ8, 0, 7, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, 0, 0, 32'hffff_ffff));
      drive_item(field_req(pbs_pkg::FUNC_READ8, 0, 7, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, 5, 12, 32'h0000_01ab));
      drive_item(field_req(pbs_pkg::FUNC_READ8, 5, 12, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_READ32, 0, 0, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE32, 3, 0, 32'hdead_beef));
      drive_item(field_req(pbs_pkg::FUNC_READ32, 3, 0, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_READ8, 4, 11, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, 8, 15, 32'hffff_ff5a));
      drive_item(field_req(pbs_pkg::FUNC_READ32, 0, LAST_BIT, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE32, LAST_BIT - 31, 0, 32'hffff_ffff));
      drive_item(field_req(pbs_pkg::FUNC_READ32, LAST_BIT - 31, 0, 32'h0));
      // at and past the end of the store
      drive_item(field_req(pbs_pkg::FUNC_WRITE32, LAST_BIT - 30, 0, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_READ32, LAST_BIT, LAST_BIT, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, LAST_BIT - 7, LAST_BIT, 32'hffff_ff00));
      drive_item(field_req(pbs_pkg::FUNC_READ8, LAST_BIT, LAST_BIT, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_READ8, LAST_BIT - 3, LAST_BIT, 32'h0));
      // reversed spans
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, 10, 9, 32'hffff_ffff));
      drive_item(field_req(pbs_pkg::FUNC_READ8, LAST_BIT, 0, 32'h0));
      // spans wider than a byte, then a byte-wide read
      drive_item(field_req(pbs_pkg::FUNC_WRITE8, 0, 8, 32'hffff_ffff));
      drive_item(field_req(pbs_pkg::FUNC_READ8, 0, LAST_BIT, 32'h0));
      drive_item(field_req(pbs_pkg::FUNC_READ8, 0, 7, 32'h0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_quiet = (i >= 600 && i < 800);
         rsp_quiet  = send_quiet;
         if (i == 1200)
            hold_off_pending = 1'b1;
         drive_item(random_req());
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[packed_bitfield_store] OK");
      else
         $display("[packed_bitfield_store] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/pbs_pkg.sv
design/pbs_ram.sv
design/pbs_ctrl.sv
design/pbs_dp.sv
design/packed_bitfield_store.sv
tb/packed_bitfield_store_checker.sv
tb/packed_bitfield_store_tb.sv
